FILE: src/continuous_line_rasterizer_macros.svh
// Assertion macros for the line rasterizer.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef CONTINUOUS_LINE_RASTERIZER_MACROS_SVH
`define CONTINUOUS_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/clr_pkg.sv
// Shared definitions for the line rasterizer.
// No dependencies; imported by the front end, queue, stepper and top level.
package clr_pkg;

  // Default coordinate width.
  localparam int COORD_BITS_DEF = 5;

  // Queue status seen by the front end and the stepper.
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

FILE: src/clr_front.sv
// Front end: accepts line commands and works out deltas and step directions.
// Depends on clr_pkg (queue status type).
module clr_front #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  logic                      start,
  input  clr_pkg::q_stat_t          q_stat,
  input  logic [COORD_BITS-1:0]     start_x,
  input  logic [COORD_BITS-1:0]     start_y,
  input  logic [COORD_BITS-1:0]     end_x,
  input  logic [COORD_BITS-1:0]     end_y,
  output logic                      push,
  output logic [6*COORD_BITS+1:0]   cmd
);
  import clr_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] xe;
    logic [COORD_BITS-1:0] ye;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  sx_neg;
    logic                  sy_neg;
  } cmd_t;

  cmd_t c;

  // Absolute deltas and direction of each axis
  always_comb begin
    c.x0     = start_x;
    c.y0     = start_y;
    c.xe     = end_x;
    c.ye     = end_y;
    c.dx     = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
    c.dy     = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
    c.sx_neg = (start_x >= end_x);
    c.sy_neg = (start_y >= end_y);
  end

  assign cmd  = c;
  assign push = start && !q_stat.full;

endmodule

FILE: src/clr_queue.sv
// Two-entry command queue between the front end and the stepper.
// Depends on clr_pkg (queue status type).
module clr_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output clr_pkg::q_stat_t stat
);
  import clr_pkg::*;

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  assign pop_data   = entries[rd_ptr];
  assign stat.valid = (count != 2'd0);
  assign stat.full  = (count == 2'd2);

endmodule

FILE: src/clr_stepper.sv
// Back end: walks one line with the Bresenham error term, one pixel a cycle within a line.
// Depends on clr_pkg (queue status type); takes commands from clr_queue.
module clr_stepper #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    corner_fill,
  input  clr_pkg::q_stat_t        q_stat,
  input  logic [6*COORD_BITS+1:0] cmd,
  output logic                    pop,
  output logic                    result_valid,
  output logic [COORD_BITS-1:0]   pixel_x,
  output logic [COORD_BITS-1:0]   pixel_y,
  output logic                    last_pixel
);
  import clr_pkg::*;

  localparam int ERR_W = COORD_BITS + 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] xe;
    logic [COORD_BITS-1:0] ye;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  sx_neg;
    logic                  sy_neg;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_CORNER = 3'b100
  } state_t;

  cmd_t                    c;
  state_t                  state, state_next;
  logic [COORD_BITS-1:0]   x, y, xe, ye;
  logic [COORD_BITS-1:0]   x_next, y_next, x_step, y_step;
  logic signed [ERR_W-1:0] err, err_next, e2, dxs, dyn;
  logic                    sx_neg, sy_neg;
  logic                    step_x, step_y, is_last;
  logic                    out_v_next, out_last_next;

  assign c = cmd;

  // Step decision for the current pixel
  always_comb begin
    e2      = err <<< 1;
    step_x  = (e2 >= dyn);
    step_y  = (e2 <= dxs);
    is_last = (step_x && (x == xe)) || (step_y && (y == ye));
    x_step  = sx_neg ? x - COORD_BITS'(1) : x + COORD_BITS'(1);
    y_step  = sy_neg ? y - COORD_BITS'(1) : y + COORD_BITS'(1);
  end

  // Sequencer: run emits the pixel, corner emits the extra brush pixel
  always_comb begin
    state_next    = state;
    x_next        = x;
    y_next        = y;
    err_next      = err;
    out_v_next    = 1'b0;
    out_last_next = 1'b0;
    pop           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_stat.valid) begin
          pop        = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        out_v_next = 1'b1;
        if (is_last) begin
          out_last_next = 1'b1;
          state_next    = ST_IDLE;
        end else if (step_x && step_y && corner_fill) begin
          x_next     = x_step;
          err_next   = err + dyn;
          state_next = ST_CORNER;
        end else begin
          if (step_x) x_next = x_step;
          if (step_y) y_next = y_step;
          err_next = err + (step_x ? dyn : '0) + (step_y ? dxs : '0);
        end
      end
      ST_CORNER: begin
        out_v_next = 1'b1;
        y_next     = y_step;
        err_next   = err + dxs;
        state_next = ST_RUN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      last_pixel   <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= out_v_next;
      last_pixel   <= out_last_next;
    end
  end

  // Walk registers and output pixel
  always_ff @(posedge clk) begin
    pixel_x <= x;
    pixel_y <= y;
    if (pop) begin
      x      <= c.x0;
      y      <= c.y0;
      xe     <= c.xe;
      ye     <= c.ye;
      sx_neg <= c.sx_neg;
      sy_neg <= c.sy_neg;
      dxs    <= $signed(ERR_W'(c.dx));
      dyn    <= -$signed(ERR_W'(c.dy));
      err    <= $signed(ERR_W'(c.dx)) - $signed(ERR_W'(c.dy));
    end else begin
      x   <= x_next;
      y   <= y_next;
      err <= err_next;
    end
  end

endmodule

FILE: src/continuous_line_rasterizer.sv
// Line rasterizer top level: config register, front end, queue and stepper.
// Depends on clr_pkg, clr_front, clr_queue, clr_stepper and the macros header.
//
// Usage:
//   A line command (start_x, start_y, end_x, end_y) is taken at a clock edge
//   with start high and busy low. busy is high while the two-entry command
//   queue is full, so up to two lines can wait behind the one being drawn.
//   Pixels come out on pixel_x / pixel_y, one per cycle within a line,
//   each marked by result_valid for exactly one cycle; last_pixel flags
//   the final pixel. With corner_fill set (cfg_we / cfg_wdata), each
//   diagonal step inserts the corner pixel at the new x and old y.
//   An accepted command waits in the queue until the idle stepper pops and
//   loads it; the next command is loaded only after the last pixel of the
//   current line. The receiver cannot stall; results are never held back.
//   Reset (rst, synchronous) empties the queue, idles the stepper and clears
//   corner_fill. The user must write corner_fill only while the block is
//   idle; the block itself does not enforce this.
`include "continuous_line_rasterizer_macros.svh"
module continuous_line_rasterizer #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  output logic                  result_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);
  import clr_pkg::*;

  localparam int CMD_W = 6 * COORD_BITS + 2;

  logic             corner_fill;
  logic             push, pop;
  logic [CMD_W-1:0] push_cmd, pop_cmd;
  q_stat_t          q_stat;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_fill <= 1'b0;
    end else if (cfg_we) begin
      corner_fill <= cfg_wdata;
    end
  end

  assign busy = q_stat.full;

  clr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .start   (start),
    .q_stat  (q_stat),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .push    (push),
    .cmd     (push_cmd)
  );

  clr_queue #(.WIDTH(CMD_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .stat      (q_stat)
  );

  clr_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk          (clk),
    .rst          (rst),
    .corner_fill  (corner_fill),
    .q_stat       (q_stat),
    .cmd          (pop_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_pixel   (last_pixel)
  );

  // Checks
  `CLR_ASSERT_IMP(a_last_has_valid, last_pixel, result_valid, "last_pixel without a beat")
  `CLR_ASSERT_NXT(a_gap_after_last, result_valid && last_pixel, !result_valid, "no gap after line")
  `CLR_ASSERT_NXT(a_line_contiguous, result_valid && !last_pixel, result_valid, "line broken off")
  `CLR_ASSERT_NXT(a_step_x_unit, result_valid && !last_pixel, (pixel_x == $past(pixel_x)) || (pixel_x == $past(pixel_x) + 1'b1) || (pixel_x == $past(pixel_x) - 1'b1), "x jumped")

endmodule
